FILE: rtl/lkvc_pkg.sv
// Package for the LRU key-value cache: control types and fixed constants.
// No dependencies; used by the cell and the top level.
`timescale 1ns / 1ps

package lkvc_pkg;

	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic hit;
		logic is_put;
		logic evict;
		logic insert;
	} lkvc_op_t;

endpackage

FILE: rtl/lkvc_cell.sv
// One entry of the LRU key-value cache: key, value, valid mark and recency rank.
// Depends on lkvc_pkg for the broadcast operation type.
`timescale 1ns / 1ps

module lkvc_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int RANK_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  lkvc_pkg::lkvc_op_t    op,
	input  logic [KEY_BITS-1:0]   wr_key,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic [RANK_BITS-1:0]  touch_rank,
	input  logic [RANK_BITS-1:0]  last_rank,
	input  logic                  free_in,
	output logic                  free_out,
	output logic                  match,
	output logic [VALUE_BITS-1:0] hit_value,
	output logic [RANK_BITS-1:0]  hit_rank
);
	import lkvc_pkg::*;

	logic                  valid_q;
	logic [RANK_BITS-1:0]  rank_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  victim;
	logic                  take_free;
	logic                  older_shift;
	logic                  write_en;

	assign match       = valid_q && (key_q == wr_key);
	assign hit_value   = match ? value_q : '0;
	assign hit_rank    = match ? rank_q : '0;
	assign victim      = valid_q && (rank_q == last_rank);
	assign take_free   = !valid_q && !free_in;
	assign free_out    = free_in || !valid_q;
	assign older_shift = valid_q && (rank_q < touch_rank);
	assign write_en    = en && ((op.hit && op.is_put && match) || (op.evict && victim) ||
		(op.insert && take_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (en) begin
			if (op.hit) begin
				if (match) begin
					rank_q <= '0;
				end else if (older_shift) begin
					rank_q <= rank_q + 1'b1;
				end
			end else if (op.evict) begin
				if (victim) begin
					rank_q <= '0;
				end else if (older_shift) begin
					rank_q <= rank_q + 1'b1;
				end
			end else if (op.insert) begin
				if (take_free) begin
					valid_q <= 1'b1;
					rank_q  <= '0;
				end else if (valid_q) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			key_q   <= wr_key;
			value_q <= wr_value;
		end
	end

endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: input capture, a row of entry cells, result register.
// Depends on lkvc_pkg and lkvc_cell.
`timescale 1ns / 1ps

// Usage.
// A command beat is taken at a rising edge with start high and busy low; it carries
// action (get or put), key and value. busy is high for the one cycle in which every
// cell compares its key, the hit, victim and free slot are resolved along the row and
// all cells update their ranks, keys and values together.
// The result beat (hit, read_value, evicted) is shown with done high for exactly one
// cycle, the cycle after the compare cycle. The receiver cannot stall it.
// A new command may be given in the cycle that done is high; no command is taken while
// busy is high, so a command cannot overlap the compare-and-update cycle of the last one.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// low only while a command is being worked on. Capacity zero acts as one and values
// above ENTRIES act as ENTRIES.
// Reset clears all valid marks, ranks and the occupancy, and sets the capacity to 16.
// No clearing pass is needed, so commands are taken in the first cycle after reset.
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic signed [KEY_BITS-1:0]   key,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         done,
	output logic                         hit,
	output logic signed [VALUE_BITS-1:0] read_value,
	output logic                         evicted,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_data
);
	import lkvc_pkg::*;

	localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_BITS  = $clog2(ENTRIES + 1);
	localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
	localparam logic [CMP_BITS-1:0] ENTRIES_C = CMP_BITS'(ENTRIES);

	logic                  busy_q;
	logic                  done_q;
	logic                  action_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [OCC_BITS-1:0]   occ_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  evicted_q;

	logic [CMP_BITS-1:0]   cap_ext;
	logic [CMP_BITS-1:0]   eff_cap;
	logic                  full;
	logic [RANK_BITS-1:0]  last_rank;
	logic [RANK_BITS-1:0]  touch_rank;
	logic                  any_match;
	logic [VALUE_BITS-1:0] hit_value_or;
	logic [RANK_BITS-1:0]  hit_rank_or;
	lkvc_op_t              op;

	logic                  free_chain [ENTRIES+1];
	logic                  cell_match [ENTRIES];
	logic [VALUE_BITS-1:0] cell_value [ENTRIES];
	logic [RANK_BITS-1:0]  cell_rank  [ENTRIES];

	assign busy      = busy_q;
	assign done      = done_q;
	assign hit       = hit_q;
	assign read_value = read_value_q;
	assign evicted   = evicted_q;
	assign cfg_ready = !busy_q;

	assign cap_ext = CMP_BITS'(cap_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_BITS'(1);
		end else if (cap_ext > ENTRIES_C) begin
			eff_cap = ENTRIES_C;
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full      = CMP_BITS'(occ_q) >= eff_cap;
	assign last_rank = RANK_BITS'(occ_q - 1'b1);

	always_comb begin
		any_match    = 1'b0;
		hit_value_or = '0;
		hit_rank_or  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			any_match    = any_match | cell_match[i];
			hit_value_or = hit_value_or | cell_value[i];
			hit_rank_or  = hit_rank_or | cell_rank[i];
		end
	end

	assign touch_rank = any_match ? hit_rank_or : last_rank;
	assign op.hit     = any_match;
	assign op.is_put  = (action_q == ACT_PUT);
	assign op.evict   = !any_match && op.is_put && full;
	assign op.insert  = !any_match && op.is_put && !full && free_chain[ENTRIES];

	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkvc_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.RANK_BITS  (RANK_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (busy_q),
			.op         (op),
			.wr_key     (key_q),
			.wr_value   (value_q),
			.touch_rank (touch_rank),
			.last_rank  (last_rank),
			.free_in    (free_chain[g]),
			.free_out   (free_chain[g+1]),
			.match      (cell_match[g]),
			.hit_value  (cell_value[g]),
			.hit_rank   (cell_rank[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cap_q  <= CAP_RESET;
			occ_q  <= '0;
		end else begin
			busy_q <= start && !busy_q;
			done_q <= busy_q;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (busy_q && op.insert) begin
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			action_q <= action;
			key_q    <= key;
			value_q  <= value;
		end
		if (busy_q) begin
			hit_q        <= any_match;
			read_value_q <= (any_match && !op.is_put) ? hit_value_or : '0;
			evicted_q    <= op.evict;
		end
	end

endmodule

FILE: rtl/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg through the top level it watches.
`timescale 1ns / 1ps

module lkvc_checker #(
	parameter int VALUE_BITS = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         hit,
	input logic                         evicted,
	input logic signed [VALUE_BITS-1:0] read_value
);

	a_cmd_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("Accepted command did not enter the compare cycle.");

	a_busy_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("Compare cycle did not produce exactly one result beat.");

	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("Result beat without a preceding compare cycle.");

	a_hit_evict_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted) && (read_value == '0 || hit))
		else $error("Result beat mixes hit with eviction or shows data on a miss.");

endmodule

bind lru_key_value_cache lkvc_checker #(.VALUE_BITS(VALUE_BITS)) u_lkvc_checker (.*);
